// ===== src/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the ordered list table engine.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int CAPACITY = 64;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_GET     = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [31:0] coef;
    logic        [15:0] expo;
  } entry_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] coef;
    logic        [15:0] expo;
    logic        [6:0]  entry_count;
    logic               is_empty;
    logic               is_full;
  } res_t;

endpackage

// ===== src/olt_in_if.sv =====
// ----------------------------------------------------------------------------
// olt_in_if
// Request channel: valid/ready handshake with opcode, position and entry.
// ----------------------------------------------------------------------------
interface olt_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [6:0]  position;
  logic signed [31:0] coef;
  logic        [15:0] expo;

  modport source (output valid, output opcode, output position, output coef,
                  output expo, input ready);
  modport sink   (input valid, input opcode, input position, input coef,
                  input expo, output ready);
endinterface

// ===== src/olt_out_if.sv =====
// ----------------------------------------------------------------------------
// olt_out_if
// Result channel: valid/ready handshake with status and returned entry.
// ----------------------------------------------------------------------------
interface olt_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] out_coef;
  logic        [15:0] out_expo;
  logic        [6:0]  entry_count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output ok, output out_coef, output out_expo,
                  output entry_count, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input ok, input out_coef, input out_expo,
                  input entry_count, input is_empty, input is_full,
                  output ready);
endinterface

// ===== src/olt_mem.sv =====
// ----------------------------------------------------------------------------
// olt_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olt_mem #(
  parameter int DEPTH = olt_pkg::CAPACITY,
  parameter int AW    = $clog2(olt_pkg::CAPACITY)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output olt_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  olt_pkg::entry_t wr_data
);

  olt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/olt_ctrl.sv =====
// ----------------------------------------------------------------------------
// olt_ctrl
// Request sequencer: range checks, entry count, and the read/write-back
// shift walk over the entry store.
// ----------------------------------------------------------------------------
module olt_ctrl #(
  parameter int CAPACITY = olt_pkg::CAPACITY,
  parameter int AW       = $clog2(olt_pkg::CAPACITY)
) (
  input  logic            clk,
  input  logic            rst_n,
  olt_in_if.sink          in_ch,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  olt_pkg::entry_t rd_data,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output olt_pkg::entry_t wr_data,
  output logic            res_valid,
  input  logic            res_ready,
  output olt_pkg::res_t   res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  olt_pkg::state_t state_r, state_nxt;
  logic [2:0]      op_r, op_nxt;
  logic            ok_r, ok_nxt;
  olt_pkg::entry_t new_r, new_nxt;
  olt_pkg::entry_t res_ent_r, res_ent_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            iss_r, iss_nxt;
  logic            first_r, first_nxt;
  logic            pend_r, pend_nxt;
  logic            pend_first_r, pend_first_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          in_range;
  logic          ins_fit;
  logic          acc;
  logic          is_ins;

  assign in_ch.ready = (state_r == olt_pkg::ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign pos_x       = XW'(in_ch.position);
  assign cnt_x       = XW'(count_r);
  assign in_range    = pos_x < cnt_x;
  assign ins_fit     = (pos_x <= cnt_x) && (count_r != CAP_C);
  assign is_ins      = (op_r == olt_pkg::OP_INSERT);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ok_nxt         = ok_r;
    new_nxt        = new_r;
    res_ent_nxt    = res_ent_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    pend_addr_nxt  = pend_addr_r;
    iss_nxt        = iss_r;
    first_nxt      = first_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    count_nxt      = count_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = pend_addr_r;
    wr_data        = rd_data;
    res_valid      = 1'b0;

    unique case (state_r)
      olt_pkg::ST_IDLE: begin
        if (acc) begin
          op_nxt      = in_ch.opcode;
          new_nxt     = '{coef: in_ch.coef, expo: in_ch.expo};
          pos_nxt     = pos_x[AW-1:0];
          res_ent_nxt = '0;
          ok_nxt      = 1'b0;
          iss_nxt     = 1'b0;
          first_nxt   = 1'b0;
          state_nxt   = olt_pkg::ST_FIN;
          unique case (in_ch.opcode)
            olt_pkg::OP_INSERT: begin
              if (ins_fit) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r + CW'(1);
                // walk from the tail down to the position, moving each entry up
                iss_nxt   = (pos_x != cnt_x);
                idx_nxt   = AW'(cnt_x - XW'(1));
                last_nxt  = pos_x[AW-1:0];
                state_nxt = olt_pkg::ST_RUN;
              end
            end
            olt_pkg::OP_DELETE: begin
              if (in_range) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - CW'(1);
                // first read returns the entry, the rest move down one place
                iss_nxt   = 1'b1;
                first_nxt = 1'b1;
                idx_nxt   = pos_x[AW-1:0];
                last_nxt  = AW'(cnt_x - XW'(1));
                state_nxt = olt_pkg::ST_RUN;
              end
            end
            olt_pkg::OP_REPLACE: begin
              if (in_range) begin
                ok_nxt    = 1'b1;
                state_nxt = olt_pkg::ST_PUT;
              end
            end
            olt_pkg::OP_GET: begin
              if (in_range) begin
                ok_nxt    = 1'b1;
                iss_nxt   = 1'b1;
                first_nxt = 1'b1;
                idx_nxt   = pos_x[AW-1:0];
                last_nxt  = pos_x[AW-1:0];
                state_nxt = olt_pkg::ST_RUN;
              end
            end
            olt_pkg::OP_CLEAR: begin
              ok_nxt    = 1'b1;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      olt_pkg::ST_RUN: begin
        if (iss_r) begin
          rd_en          = 1'b1;
          pend_nxt       = 1'b1;
          pend_first_nxt = first_r;
          first_nxt      = 1'b0;
          pend_addr_nxt  = is_ins ? (idx_r + AW'(1)) : (idx_r - AW'(1));
          if (idx_r == last_r) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = is_ins ? (idx_r - AW'(1)) : (idx_r + AW'(1));
          end
        end else begin
          pend_nxt = 1'b0;
        end
        // data from last cycle's read: captured as result or written back shifted
        if (pend_r) begin
          if (pend_first_r) begin
            res_ent_nxt = rd_data;
          end else begin
            wr_en = 1'b1;
          end
        end
        if (!iss_r && !pend_r) begin
          state_nxt = is_ins ? olt_pkg::ST_PUT : olt_pkg::ST_FIN;
        end
      end

      olt_pkg::ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = new_r;
        state_nxt = olt_pkg::ST_FIN;
      end

      olt_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = olt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = olt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olt_pkg::ST_IDLE;
      count_r <= '0;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ok_r         <= ok_nxt;
    new_r        <= new_nxt;
    res_ent_r    <= res_ent_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    last_r       <= last_nxt;
    pend_addr_r  <= pend_addr_nxt;
    first_r      <= first_nxt;
    pend_first_r <= pend_first_nxt;
  end

  assign res.ok          = ok_r;
  assign res.coef        = res_ent_r.coef;
  assign res.expo        = res_ent_r.expo;
  assign res.entry_count = 7'(count_r);
  assign res.is_empty    = (count_r == '0);
  assign res.is_full     = (count_r == CAP_C);

  // shift walk never writes the entry it reads in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != olt_pkg::ST_IDLE))
    else $error("accepted request did not start");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result dropped while stalled");

endmodule

// ===== src/ordered_list_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table_engine_core
// Fixed-capacity ordered list of (coefficient, exponent) entries.
// ----------------------------------------------------------------------------
// Flow: get and delete walk the N entries read (moved plus the returned
//   one); insert walks the N entries moved, then writes the new entry; replace
//   writes the entry in place; clear and rejected requests go to the result.
// Requests: one at a time; the longest is a head insert or head delete on a
//   near-full list, set by the one-entry-per-cycle walk.
// Reset: entry count and control clear; the entry store is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_core #(
  parameter int CAPACITY = olt_pkg::CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  olt_in_if.sink    in_ch,
  olt_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  olt_pkg::entry_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  olt_pkg::entry_t wr_data;
  logic            res_valid;
  logic            res_ready;
  olt_pkg::res_t   res;

  logic          out_valid_r, out_valid_nxt;
  olt_pkg::res_t out_data_r, out_data_nxt;

  olt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  olt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register: refills on the same cycle the held result transfers
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_data_r.ok;
  assign out_ch.out_coef    = out_data_r.coef;
  assign out_ch.out_expo    = out_data_r.expo;
  assign out_ch.entry_count = out_data_r.entry_count;
  assign out_ch.is_empty    = out_data_r.is_empty;
  assign out_ch.is_full     = out_data_r.is_full;

endmodule
